FILE: rtl/wsfp_pkg.sv
// shared types and constants of the websocket frame parser
package wsfp_pkg;

    // widths of the stream items and of the length fields
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned OPCODE_W      = 4;
    localparam int unsigned FRAME_LEN_W   = 64;
    localparam int unsigned LEN7_W        = 7;
    localparam int unsigned EXT_CNT_W     = 4;
    localparam int unsigned KEY_IDX_W     = 2;
    localparam int unsigned KEY_BYTES     = 4;
    localparam int unsigned M_TDATA_W     = 16;
    localparam int unsigned M_TUSER_W     = 2;

    // default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // header decode constants
    localparam logic [LEN7_W-1:0]    LEN_EXT16    = 7'd126;
    localparam logic [LEN7_W-1:0]    LEN_EXT64    = 7'd127;
    localparam logic [EXT_CNT_W-1:0] EXT16_BYTES  = 4'd2;
    localparam logic [EXT_CNT_W-1:0] EXT64_BYTES  = 4'd8;
    localparam logic [KEY_IDX_W-1:0] KEY_LAST_IDX = 2'd3;
    localparam int unsigned          MASK_BIT_POS = 7;

    // parse phase of the front
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    // command kinds handed from front to back
    typedef enum logic [1:0] {
        CMD_KEY   = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_EMPTY = 2'd2
    } cmd_kind_t;

    // one queued command
    typedef struct packed {
        cmd_kind_t              kind;
        logic [BYTE_W-1:0]      data;
        logic [KEY_IDX_W-1:0]   idx;
        logic [OPCODE_W-1:0]    opcode;
        logic                   masked;
        logic                   last;
    } cmd_t;

endpackage

FILE: rtl/websocket_frame_parser.sv
// top level of the websocket frame parser
// Receives a link stream one byte per item and parses WebSocket frames: opcode from
// header byte 0, mask flag and 7-bit length from byte 1, optional 16- or 64-bit
// big-endian extended length, optional 4-byte mask key, then the payload. Each payload
// byte comes out unmasked as one result item; a frame of zero length gives one marker
// item with has_byte low. Header, length and key bytes give no result. FIN and reserved
// bits are ignored. One byte is accepted every cycle while the result side keeps up;
// a byte that yields a result passes through the command queue and then the result register.
// The front parser and the result stage are joined by a command queue of QUEUE_DEPTH
// entries. Payload, marker and key bytes each take one entry, header and length bytes
// take none, so while m_tready is low the slave side keeps accepting until QUEUE_DEPTH
// entries wait behind the held result. Once the queue is full s_tready stays low for
// the cycle in which an entry drains, since it follows the registered fill count.
module websocket_frame_parser #(
    parameter int unsigned QUEUE_DEPTH = wsfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // link_byte[7:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wsfp_pkg::M_TDATA_W-1:0]      m_tdata,   // frame_opcode_out[3:0], payload_byte[11:4]
    output logic [wsfp_pkg::M_TUSER_W-1:0]      m_tuser,   // has_byte[0], was_masked[1]
    output logic                                m_tlast    // frame_end
);

    logic               room;
    logic               cmd_valid;
    wsfp_pkg::cmd_t     cmd;
    logic               pop;
    logic               head_valid;
    wsfp_pkg::cmd_t     head_cmd;

    assign s_tready = room;

    // header parsing and item classification
    wsfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .room      (room),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // command queue
    wsfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_valid),
        .push_cmd   (cmd),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // unmasking and result stage
    wsfp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: rtl/wsfp_front.sv
// front: accepts link bytes, parses headers and issues commands to the back
module wsfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic [7:0]          s_tdata,     // link_byte[7:0]
    input  logic                room,
    output logic                cmd_valid,
    output wsfp_pkg::cmd_t      cmd
);

    wsfp_pkg::phase_t                        phase_reg, phase_next;
    logic [wsfp_pkg::OPCODE_W-1:0]           opcode_reg, opcode_next;
    logic                                    masked_reg, masked_next;
    logic [wsfp_pkg::EXT_CNT_W-1:0]          ext_left_reg, ext_left_next;
    logic [wsfp_pkg::FRAME_LEN_W-1:0]        len_reg, len_next;
    logic [wsfp_pkg::KEY_IDX_W-1:0]          key_idx_reg, key_idx_next;
    logic [wsfp_pkg::KEY_IDX_W-1:0]          pos_reg, pos_next;

    logic                                    accept;
    logic [wsfp_pkg::LEN7_W-1:0]             len7;
    logic                                    hdr_masked;
    logic [wsfp_pkg::FRAME_LEN_W-1:0]        len7_ext;
    logic [wsfp_pkg::FRAME_LEN_W-1:0]        ext_len;
    logic                                    ext_done;
    logic                                    data_last;

    assign accept     = s_tvalid & room;
    assign len7       = s_tdata[wsfp_pkg::LEN7_W-1:0];
    assign hdr_masked = s_tdata[wsfp_pkg::MASK_BIT_POS];
    assign len7_ext   = {{(wsfp_pkg::FRAME_LEN_W - wsfp_pkg::LEN7_W){1'b0}}, len7};
    assign ext_len    = {len_reg[wsfp_pkg::FRAME_LEN_W-wsfp_pkg::BYTE_W-1:0], s_tdata};
    assign ext_done   = (ext_left_reg == wsfp_pkg::EXT_CNT_W'(1));
    assign data_last  = (len_reg == wsfp_pkg::FRAME_LEN_W'(1));

    // next state of the parser
    always_comb begin
        phase_next    = phase_reg;
        opcode_next   = opcode_reg;
        masked_next   = masked_reg;
        ext_left_next = ext_left_reg;
        len_next      = len_reg;
        key_idx_next  = key_idx_reg;
        pos_next      = pos_reg;
        if (accept) begin
            unique case (phase_reg)
                wsfp_pkg::PH_HDR0: begin
                    opcode_next = s_tdata[wsfp_pkg::OPCODE_W-1:0];
                    phase_next  = wsfp_pkg::PH_HDR1;
                end
                wsfp_pkg::PH_HDR1: begin
                    masked_next  = hdr_masked;
                    key_idx_next = '0;
                    pos_next     = '0;
                    if (len7 == wsfp_pkg::LEN_EXT16) begin
                        len_next      = '0;
                        ext_left_next = wsfp_pkg::EXT16_BYTES;
                        phase_next    = wsfp_pkg::PH_EXT;
                    end else if (len7 == wsfp_pkg::LEN_EXT64) begin
                        len_next      = '0;
                        ext_left_next = wsfp_pkg::EXT64_BYTES;
                        phase_next    = wsfp_pkg::PH_EXT;
                    end else begin
                        len_next = len7_ext;
                        if (hdr_masked) begin
                            phase_next = wsfp_pkg::PH_KEY;
                        end else if (len7 == '0) begin
                            phase_next = wsfp_pkg::PH_HDR0;
                        end else begin
                            phase_next = wsfp_pkg::PH_DATA;
                        end
                    end
                end
                wsfp_pkg::PH_EXT: begin
                    len_next      = ext_len;
                    ext_left_next = ext_left_reg - wsfp_pkg::EXT_CNT_W'(1);
                    if (ext_done) begin
                        if (masked_reg) begin
                            phase_next = wsfp_pkg::PH_KEY;
                        end else if (ext_len == '0) begin
                            phase_next = wsfp_pkg::PH_HDR0;
                        end else begin
                            phase_next = wsfp_pkg::PH_DATA;
                        end
                    end
                end
                wsfp_pkg::PH_KEY: begin
                    key_idx_next = key_idx_reg + wsfp_pkg::KEY_IDX_W'(1);
                    if (key_idx_reg == wsfp_pkg::KEY_LAST_IDX) begin
                        phase_next = (len_reg == '0) ? wsfp_pkg::PH_HDR0 : wsfp_pkg::PH_DATA;
                    end
                end
                wsfp_pkg::PH_DATA: begin
                    len_next = len_reg - wsfp_pkg::FRAME_LEN_W'(1);
                    pos_next = pos_reg + wsfp_pkg::KEY_IDX_W'(1);
                    if (data_last) begin
                        phase_next = wsfp_pkg::PH_HDR0;
                    end
                end
                default: begin
                    phase_next = wsfp_pkg::PH_HDR0;
                end
            endcase
        end
    end

    // command issued for the accepted item
    always_comb begin
        cmd_valid  = 1'b0;
        cmd.kind   = wsfp_pkg::CMD_DATA;
        cmd.data   = s_tdata;
        cmd.idx    = pos_reg;
        cmd.opcode = opcode_reg;
        cmd.masked = masked_reg;
        cmd.last   = data_last;
        if (accept) begin
            unique case (phase_reg)
                wsfp_pkg::PH_HDR0: begin
                    cmd_valid = 1'b0;
                end
                wsfp_pkg::PH_HDR1: begin
                    cmd.kind   = wsfp_pkg::CMD_EMPTY;
                    cmd.masked = hdr_masked;
                    cmd.last   = 1'b1;
                    cmd_valid  = !hdr_masked && (len7 == '0);
                end
                wsfp_pkg::PH_EXT: begin
                    cmd.kind  = wsfp_pkg::CMD_EMPTY;
                    cmd.last  = 1'b1;
                    cmd_valid = ext_done && !masked_reg && (ext_len == '0);
                end
                wsfp_pkg::PH_KEY: begin
                    cmd.idx   = key_idx_reg;
                    cmd_valid = 1'b1;
                    if ((key_idx_reg == wsfp_pkg::KEY_LAST_IDX) && (len_reg == '0)) begin
                        // empty masked frame: the key is never used
                        cmd.kind = wsfp_pkg::CMD_EMPTY;
                        cmd.last = 1'b1;
                    end else begin
                        cmd.kind = wsfp_pkg::CMD_KEY;
                    end
                end
                wsfp_pkg::PH_DATA: begin
                    cmd_valid = 1'b1;
                end
                default: begin
                    cmd_valid = 1'b0;
                end
            endcase
        end
    end

    // parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= wsfp_pkg::PH_HDR0;
        end else begin
            phase_reg <= phase_next;
        end
        opcode_reg   <= opcode_next;
        masked_reg   <= masked_next;
        ext_left_reg <= ext_left_next;
        len_reg      <= len_next;
        key_idx_reg  <= key_idx_next;
        pos_reg      <= pos_next;
    end

endmodule

FILE: rtl/wsfp_queue.sv
// small command queue between front and back
module wsfp_queue #(
    parameter int unsigned DEPTH = wsfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsfp_pkg::cmd_t      push_cmd,
    output logic                room,
    input  logic                pop,
    output logic                head_valid,
    output wsfp_pkg::cmd_t      head_cmd
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    wsfp_pkg::cmd_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign room       = (count_reg != CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/wsfp_back.sv
// back: holds the mask key, unmasks payload and drives the result register
module wsfp_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                head_valid,
    input  wsfp_pkg::cmd_t                      head_cmd,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [wsfp_pkg::M_TDATA_W-1:0]      m_tdata,   // frame_opcode_out[3:0], payload_byte[11:4]
    output logic [wsfp_pkg::M_TUSER_W-1:0]      m_tuser,   // has_byte[0], was_masked[1]
    output logic                                m_tlast
);

    logic [wsfp_pkg::BYTE_W-1:0]    key_reg [wsfp_pkg::KEY_BYTES];
    logic                           out_valid_reg, out_valid_next;
    logic [wsfp_pkg::OPCODE_W-1:0]  out_opcode_reg;
    logic [wsfp_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                           out_has_reg;
    logic                           out_last_reg;
    logic                           out_masked_reg;
    logic                           load_out;
    logic [wsfp_pkg::BYTE_W-1:0]    key_byte;
    logic [wsfp_pkg::BYTE_W-1:0]    plain_byte;

    // take a command whenever the result register is free or being drained
    assign pop      = head_valid && (!out_valid_reg || m_tready);
    assign load_out = pop && (head_cmd.kind != wsfp_pkg::CMD_KEY);
    assign key_byte = key_reg[head_cmd.idx];

    // unmask a payload byte; the empty marker carries a zero byte
    always_comb begin
        unique case (head_cmd.kind)
            wsfp_pkg::CMD_DATA:  plain_byte = head_cmd.masked ? (head_cmd.data ^ key_byte)
                                                              : head_cmd.data;
            default:             plain_byte = '0;
        endcase
    end

    // result valid tracking
    always_comb begin
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_opcode_reg <= head_cmd.opcode;
            out_byte_reg   <= plain_byte;
            out_has_reg    <= (head_cmd.kind == wsfp_pkg::CMD_DATA);
            out_last_reg   <= head_cmd.last;
            out_masked_reg <= head_cmd.masked;
        end
    end

    // mask key bytes
    always_ff @(posedge aclk) begin
        if (pop && (head_cmd.kind == wsfp_pkg::CMD_KEY)) begin
            key_reg[head_cmd.idx] <= head_cmd.data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(wsfp_pkg::M_TDATA_W - wsfp_pkg::OPCODE_W - wsfp_pkg::BYTE_W){1'b0}},
                       out_byte_reg, out_opcode_reg};
    assign m_tuser  = {out_masked_reg, out_has_reg};
    assign m_tlast  = out_last_reg;

endmodule
